/* rtl/core/pcs_pkg.sv */
// Package for the priority command selector: word types, register codes and
// reset constants. Used by every module under rtl/core; depends on nothing.
`default_nettype none

package pcs_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int AGE_BITS_DEF = 16;

    localparam int VEL_W     = 32;
    localparam int CH_W      = 2;
    localparam int LOCK_W    = 16;
    localparam int EN_W      = 4;
    localparam int LOCK_REGS = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [LOCK_W-1:0] LOCK_RST_HI = 16'd300;  // 10 s at 30 Hz
    localparam logic [LOCK_W-1:0] LOCK_RST_LO = 16'd6;    // 0.2 s at 30 Hz
    localparam logic [EN_W-1:0]   EN_RST      = 4'b0001;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCK_0 = 3'd0,
        REG_LOCK_1 = 3'd1,
        REG_LOCK_2 = 3'd2,
        REG_LOCK_3 = 3'd3,
        REG_ENABLE = 3'd4
    } t_reg_idx;

    typedef enum logic [0:0] {
        KIND_MSG  = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic signed [VEL_W-1:0] lin_x;
        logic signed [VEL_W-1:0] lin_y;
        logic signed [VEL_W-1:0] lin_z;
        logic signed [VEL_W-1:0] ang_x;
        logic signed [VEL_W-1:0] ang_y;
        logic signed [VEL_W-1:0] ang_z;
    } t_cmd;

    typedef struct packed {
        t_kind                   kind;
        logic [CH_W-1:0]         channel;
        logic signed [VEL_W-1:0] linear_x;
        logic signed [VEL_W-1:0] linear_y;
        logic signed [VEL_W-1:0] linear_z;
        logic signed [VEL_W-1:0] angular_x;
        logic signed [VEL_W-1:0] angular_y;
        logic signed [VEL_W-1:0] angular_z;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0]         source;
        logic signed [VEL_W-1:0] out_linear_x;
        logic signed [VEL_W-1:0] out_linear_y;
        logic signed [VEL_W-1:0] out_linear_z;
        logic signed [VEL_W-1:0] out_angular_x;
        logic signed [VEL_W-1:0] out_angular_y;
        logic signed [VEL_W-1:0] out_angular_z;
    } t_out_word;

    // arbitration status handed from the arbiter to the top level
    typedef struct packed {
        logic found;
        logic fresh;
    } t_pick;

endpackage

`default_nettype wire

/* rtl/core/pcs_cfg.sv */
// Configuration registers: per-channel lock windows and channel enables.
// Depends on pcs_pkg.
`default_nettype none

module pcs_cfg #(
    parameter int CHANNELS = pcs_pkg::CHANNELS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [pcs_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    output logic [CHANNELS-1:0][pcs_pkg::LOCK_W-1:0]   o_lock,
    output logic [pcs_pkg::EN_W-1:0]                   o_enable
);

    logic [pcs_pkg::EN_W-1:0] r_enable;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lock
        if (c < pcs_pkg::LOCK_REGS) begin : g_reg
            logic [pcs_pkg::LOCK_W-1:0] r_lock;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_lock <= (c == 0) ? pcs_pkg::LOCK_RST_HI : pcs_pkg::LOCK_RST_LO;
                end else if (i_cfg_we && i_cfg_idx ==
                             (pcs_pkg::CFG_IDX_W'(pcs_pkg::REG_LOCK_0)
                              + pcs_pkg::CFG_IDX_W'(c))) begin
                    r_lock <= i_cfg_data[pcs_pkg::LOCK_W-1:0];
                end
            end
            assign o_lock[c] = r_lock;
        end else begin : g_fixed
            // no register reaches these channels
            assign o_lock[c] = pcs_pkg::LOCK_RST_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= pcs_pkg::EN_RST;
        end else if (i_cfg_we && i_cfg_idx == pcs_pkg::REG_ENABLE) begin
            r_enable <= i_cfg_data[pcs_pkg::EN_W-1:0];
        end
    end

    assign o_enable = r_enable;

endmodule

`default_nettype wire

/* rtl/core/pcs_arb.sv */
// Fixed-priority arbiter: finds the lowest live channel within its lock window
// and the mask of new marks a tick clears. Depends on pcs_pkg.
`default_nettype none

module pcs_arb #(
    parameter int CHANNELS = pcs_pkg::CHANNELS_DEF,
    parameter int AGE_BITS = pcs_pkg::AGE_BITS_DEF,
    parameter int IDX_W    = $clog2(CHANNELS)
) (
    input  wire logic [CHANNELS-1:0][AGE_BITS-1:0]          i_age,
    input  wire logic [CHANNELS-1:0][pcs_pkg::LOCK_W-1:0]   i_lock,
    input  wire logic [CHANNELS-1:0]                        i_ever,
    input  wire logic [CHANNELS-1:0]                        i_pend,
    output pcs_pkg::t_pick                                  o_pick,
    output logic [IDX_W-1:0]                                o_win,
    output logic [CHANNELS-1:0]                             o_clr
);

    localparam int CMP_W = (AGE_BITS > pcs_pkg::LOCK_W) ? AGE_BITS : pcs_pkg::LOCK_W;

    logic [CHANNELS-1:0] hit;
    logic [CHANNELS-1:0] seen;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            hit[c] = i_ever[c] && (CMP_W'(i_age[c]) <= CMP_W'(i_lock[c]));
        end
    end

    // seen[c]: some channel of higher priority than c is live
    always_comb begin
        seen[0] = 1'b0;
        for (int c = 1; c < CHANNELS; c++) begin
            seen[c] = seen[c-1] | hit[c-1];
        end
    end

    always_comb begin
        o_win = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (hit[c]) begin
                o_win = IDX_W'(c);
            end
        end
    end

    assign o_clr        = ~seen;
    assign o_pick.found = |hit;
    assign o_pick.fresh = i_pend[o_win];

endmodule

`default_nettype wire

/* rtl/core/pcs_state.sv */
// Channel state: stored commands, ages, received and new marks.
// Depends on pcs_pkg.
`default_nettype none

module pcs_state #(
    parameter int CHANNELS = pcs_pkg::CHANNELS_DEF,
    parameter int AGE_BITS = pcs_pkg::AGE_BITS_DEF,
    parameter int IDX_W    = $clog2(CHANNELS)
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_msg_we,
    input  wire logic [IDX_W-1:0]                      i_msg_idx,
    input  wire pcs_pkg::t_cmd                         i_msg_cmd,
    input  wire logic                                  i_tick,
    input  wire logic [CHANNELS-1:0]                   i_clr,
    input  wire logic [IDX_W-1:0]                      i_rd_idx,
    output pcs_pkg::t_cmd                              o_rd_cmd,
    output logic [CHANNELS-1:0][AGE_BITS-1:0]          o_age,
    output logic [CHANNELS-1:0]                        o_ever,
    output logic [CHANNELS-1:0]                        o_pend
);

    pcs_pkg::t_cmd                      r_store [CHANNELS];
    logic [CHANNELS-1:0][AGE_BITS-1:0]  r_age;
    logic [CHANNELS-1:0]                r_ever;
    logic [CHANNELS-1:0]                r_pend;

    always_ff @(posedge i_clk) begin
        if (i_msg_we) begin
            r_store[i_msg_idx] <= i_msg_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age  <= '1;
            r_ever <= '0;
            r_pend <= '0;
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (i_msg_we && i_msg_idx == IDX_W'(c)) begin
                    r_age[c]  <= '0;
                    r_ever[c] <= 1'b1;
                    r_pend[c] <= 1'b1;
                end else if (i_tick) begin
                    if (!(&r_age[c])) begin
                        r_age[c] <= r_age[c] + AGE_BITS'(1);
                    end
                    if (i_clr[c]) begin
                        r_pend[c] <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_rd_cmd = r_store[i_rd_idx];
    assign o_age    = r_age;
    assign o_ever   = r_ever;
    assign o_pend   = r_pend;

endmodule

`default_nettype wire

/* rtl/core/priority_command_selector_unit.sv */
// Priority command selector, top level: config registers, channel state,
// arbiter and result register. Depends on pcs_pkg, pcs_cfg, pcs_state, pcs_arb.
//
// Usage: words enter on i_in_valid / o_in_stall as pcs_pkg::t_in_word. A
// message word (kind = message) stores a six-value velocity command for an
// enabled channel and restarts its age. A tick word selects the
// highest-priority channel that has a command within its lock window and,
// if that command is new, returns it on o_out_valid / i_out_stall as
// pcs_pkg::t_out_word. A result is registered and appears in the cycle after
// its tick is taken; one word per cycle is taken unless a tick is held off.
// While a result waits under i_out_stall, message words and ticks that
// produce nothing are still taken; only a tick that would produce a result
// is held off. Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) are registered.
// The user must make them with the block idle; the block does not enforce it.
// Reset clears all marks, saturates every age and loads the default lock
// windows and enables; the stored commands are left as they are.
`default_nettype none

module priority_command_selector_unit #(
    parameter int CHANNELS = pcs_pkg::CHANNELS_DEF,
    parameter int AGE_BITS = pcs_pkg::AGE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire pcs_pkg::t_in_word             i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output pcs_pkg::t_out_word                 o_out_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pcs_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(CHANNELS);

    logic [CHANNELS-1:0][pcs_pkg::LOCK_W-1:0] lock;
    logic [pcs_pkg::EN_W-1:0]                 enable;
    logic [CHANNELS-1:0][AGE_BITS-1:0]        age;
    logic [CHANNELS-1:0]                      ever;
    logic [CHANNELS-1:0]                      pend;
    logic [CHANNELS-1:0]                      clr;
    logic [IDX_W-1:0]                         win;
    pcs_pkg::t_pick                           pick;
    pcs_pkg::t_cmd                            msg_cmd;
    pcs_pkg::t_cmd                            rd_cmd;
    logic                                     accept;
    logic                                     is_tick;
    logic                                     produce;
    logic                                     msg_we;
    logic                                     ch_ok;

    logic                                     r_out_valid;
    pcs_pkg::t_out_word                       r_out_word;

    pcs_cfg #(
        .CHANNELS (CHANNELS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_lock     (lock),
        .o_enable   (enable)
    );

    pcs_arb #(
        .CHANNELS (CHANNELS),
        .AGE_BITS (AGE_BITS),
        .IDX_W    (IDX_W)
    ) u_arb (
        .i_age  (age),
        .i_lock (lock),
        .i_ever (ever),
        .i_pend (pend),
        .o_pick (pick),
        .o_win  (win),
        .o_clr  (clr)
    );

    assign is_tick = (i_in_word.kind == pcs_pkg::KIND_TICK);
    assign produce = pick.found && pick.fresh;

    // only a result-bearing tick needs the result register free
    assign o_in_stall = r_out_valid && i_out_stall && is_tick && produce;
    assign accept     = i_in_valid && !o_in_stall;

    assign ch_ok  = 32'(i_in_word.channel) < 32'(CHANNELS);
    assign msg_we = accept && !is_tick && ch_ok && enable[i_in_word.channel];

    assign msg_cmd.lin_x = i_in_word.linear_x;
    assign msg_cmd.lin_y = i_in_word.linear_y;
    assign msg_cmd.lin_z = i_in_word.linear_z;
    assign msg_cmd.ang_x = i_in_word.angular_x;
    assign msg_cmd.ang_y = i_in_word.angular_y;
    assign msg_cmd.ang_z = i_in_word.angular_z;

    pcs_state #(
        .CHANNELS (CHANNELS),
        .AGE_BITS (AGE_BITS),
        .IDX_W    (IDX_W)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_msg_we  (msg_we),
        .i_msg_idx (IDX_W'(i_in_word.channel)),
        .i_msg_cmd (msg_cmd),
        .i_tick    (accept && is_tick),
        .i_clr     (clr),
        .i_rd_idx  (win),
        .o_rd_cmd  (rd_cmd),
        .o_age     (age),
        .o_ever    (ever),
        .o_pend    (pend)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && is_tick && produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_tick && produce) begin
            r_out_word.source        <= pcs_pkg::CH_W'(win);
            r_out_word.out_linear_x  <= rd_cmd.lin_x;
            r_out_word.out_linear_y  <= rd_cmd.lin_y;
            r_out_word.out_linear_z  <= rd_cmd.lin_z;
            r_out_word.out_angular_x <= rd_cmd.ang_x;
            r_out_word.out_angular_y <= rd_cmd.ang_y;
            r_out_word.out_angular_z <= rd_cmd.ang_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire
